>>> rtl/svc_intra_inter_mb_classifier_assert.svh
// Assertion macros for the intra-inter macroblock classifier.
`ifndef SVC_INTRA_INTER_MB_CLASSIFIER_ASSERT_SVH
`define SVC_INTRA_INTER_MB_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define SVC_IIMBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SVC_IIMBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SVC_IIMBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SVC_IIMBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/svc_iimbc_pkg.sv
// Shared types and constants of the intra-inter macroblock classifier.
`default_nettype none

package svc_iimbc_pkg;

  localparam int unsigned MAX_LAYER_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_LAYER_HEIGHT_DEF = 2048;
  localparam int unsigned MODE_TABLE_DEPTH_DEF = 16384;

  localparam int INDEX_W     = 14;
  localparam int VALUE_W     = 16;
  localparam int MBPOS_W     = 7;
  localparam int DIM_W       = 13;
  localparam int STRIDE_W    = 8;
  localparam int MCODE_W     = 8;
  localparam int CROSS_W     = 5;
  localparam int CNT_W       = 5;
  localparam int PROJ_ADDR_W = INDEX_W;
  localparam int MODE_ADDR_W = 18;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CNT_W-1:0]    SCAN_LAST    = 5'd16;
  localparam logic [CNT_W-1:0]    CORNER_ISSUE = 5'd4;
  localparam logic [CNT_W-1:0]    CORNER_FIRST = 5'd2;
  localparam logic [CNT_W-1:0]    CORNER_LAST  = 5'd5;
  localparam logic [3:0]          MB_LAST      = 4'd15;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd128;

  typedef enum logic [1:0] {
    OP_COL_WR,
    OP_ROW_WR,
    OP_MODE_WR,
    OP_EVAL
  } iimbc_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_STRIDE,
    REG_LIMIT
  } iimbc_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CORNER,
    ST_FIN
  } iimbc_state_t;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
    logic [MCODE_W-1:0]  limit;
  } iimbc_cfg_t;

  typedef struct packed {
    iimbc_op_t           mode;
    logic [INDEX_W-1:0]  table_index;
    logic [VALUE_W-1:0]  table_value;
    logic [MBPOS_W-1:0]  mb_col;
    logic [MBPOS_W-1:0]  mb_row;
    logic                base_mode;
  } iimbc_item_t;

  typedef struct packed {
    logic               intra_inter;
    logic               top_left_intra;
    logic               top_right_intra;
    logic               bottom_left_intra;
    logic               bottom_right_intra;
    logic [CROSS_W-1:0] cross_x;
    logic [CROSS_W-1:0] cross_y;
  } iimbc_result_t;

endpackage

`default_nettype wire

>>> rtl/svc_iimbc_ram.sv
// Simple dual-port table RAM with registered read and address range flag.
`default_nettype none

module svc_iimbc_ram #(
  parameter int unsigned DEPTH  = 2048,
  parameter int          DATA_W = 16,
  parameter int          ADDR_W = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  output logic                   rd_hit
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic              wr_in;
  logic              rd_in;

  assign wr_in = (32'(wr_addr) < DEPTH);
  assign rd_in = (32'(rd_addr) < DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[AW'(rd_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit <= 1'b0;
    end else if (rd_en) begin
      rd_hit <= rd_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/svc_iimbc_seq.sv
// Sequencer: table writes, projection scan, corner mode lookups, result build.
`default_nettype none
`include "svc_intra_inter_mb_classifier_assert.svh"

module svc_iimbc_seq #(
  parameter int unsigned MAX_LAYER_WIDTH  = svc_iimbc_pkg::MAX_LAYER_WIDTH_DEF,
  parameter int unsigned MAX_LAYER_HEIGHT = svc_iimbc_pkg::MAX_LAYER_HEIGHT_DEF,
  parameter int unsigned MODE_TABLE_DEPTH = svc_iimbc_pkg::MODE_TABLE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire svc_iimbc_pkg::iimbc_item_t  item,
  input  wire svc_iimbc_pkg::iimbc_cfg_t   cfg,
  input  wire logic                        slot_free,
  output logic                             res_valid,
  output svc_iimbc_pkg::iimbc_result_t     res
);

  localparam int VW = svc_iimbc_pkg::VALUE_W;
  localparam int PW = svc_iimbc_pkg::PROJ_ADDR_W;
  localparam int MW = svc_iimbc_pkg::MODE_ADDR_W;
  localparam int CW = svc_iimbc_pkg::CNT_W;

  svc_iimbc_pkg::iimbc_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [svc_iimbc_pkg::MBPOS_W-1:0] mb_col_r, mb_row_r;
  logic [VW-1:0] x0_r, x15_r, y0_r, y15_r;
  logic [svc_iimbc_pkg::CROSS_W-1:0] cx_r, cy_r;
  logic          cx_done_r, cy_done_r;
  logic [3:0]    intra_r;
  logic [MW-1:0] addr_r;
  logic          ok1_r, ok2_r;

  logic          accept, eval_acc;
  logic          col_we, row_we, mode_we;
  logic          proj_rd;
  logic [PW-1:0] col_ra, row_ra, proj_wa;
  logic [VW-1:0] col_q, row_q, col_v, row_v;
  logic          col_hit, row_hit;
  logic [svc_iimbc_pkg::MCODE_W-1:0] mode_q;
  logic          mode_hit, mode_rd;
  logic [MW-1:0] mode_wa, crn_addr;

  logic [3:0]    k;
  logic          same_x, same_y;
  logic [1:0]    c_sel, c_done;
  logic [VW-1:0] xs, ys;
  logic          in_layer, ii;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      svc_iimbc_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (eval_acc) begin
          state_nxt = item.base_mode ? svc_iimbc_pkg::ST_SCAN : svc_iimbc_pkg::ST_FIN;
        end
      end
      svc_iimbc_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == svc_iimbc_pkg::SCAN_LAST) begin
          state_nxt = svc_iimbc_pkg::ST_CORNER;
          cnt_nxt   = '0;
        end
      end
      svc_iimbc_pkg::ST_CORNER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == svc_iimbc_pkg::CORNER_LAST) begin
          state_nxt = svc_iimbc_pkg::ST_FIN;
          cnt_nxt   = '0;
        end
      end
      svc_iimbc_pkg::ST_FIN: begin
        if (slot_free) begin
          state_nxt = svc_iimbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svc_iimbc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = rst_n && (state_r == svc_iimbc_pkg::ST_IDLE);
    proj_rd   = (state_r == svc_iimbc_pkg::ST_SCAN) && (cnt_r < svc_iimbc_pkg::SCAN_LAST);
    mode_rd   = (state_r == svc_iimbc_pkg::ST_CORNER);
    res_valid = (state_r == svc_iimbc_pkg::ST_FIN) && slot_free;
  end

  assign accept   = in_valid && in_ready;
  assign eval_acc = accept && (item.mode == svc_iimbc_pkg::OP_EVAL);
  assign col_we   = accept && (item.mode == svc_iimbc_pkg::OP_COL_WR);
  assign row_we   = accept && (item.mode == svc_iimbc_pkg::OP_ROW_WR);
  assign mode_we  = accept && (item.mode == svc_iimbc_pkg::OP_MODE_WR);

  assign proj_wa = PW'(item.table_index);
  assign mode_wa = MW'(item.table_index);
  assign col_ra  = PW'({mb_col_r, cnt_r[3:0]});
  assign row_ra  = PW'({mb_row_r, cnt_r[3:0]});

  svc_iimbc_ram #(
    .DEPTH  (MAX_LAYER_WIDTH),
    .DATA_W (VW),
    .ADDR_W (PW)
  ) u_col_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (col_we),
    .wr_addr (proj_wa),
    .wr_data (item.table_value),
    .rd_en   (proj_rd),
    .rd_addr (col_ra),
    .rd_data (col_q),
    .rd_hit  (col_hit)
  );

  svc_iimbc_ram #(
    .DEPTH  (MAX_LAYER_HEIGHT),
    .DATA_W (VW),
    .ADDR_W (PW)
  ) u_row_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (row_we),
    .wr_addr (proj_wa),
    .wr_data (item.table_value),
    .rd_en   (proj_rd),
    .rd_addr (row_ra),
    .rd_data (row_q),
    .rd_hit  (row_hit)
  );

  svc_iimbc_ram #(
    .DEPTH  (MODE_TABLE_DEPTH),
    .DATA_W (svc_iimbc_pkg::MCODE_W),
    .ADDR_W (MW)
  ) u_mode_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mode_we),
    .wr_addr (mode_wa),
    .wr_data (item.table_value[svc_iimbc_pkg::MCODE_W-1:0]),
    .rd_en   (mode_rd),
    .rd_addr (addr_r),
    .rd_data (mode_q),
    .rd_hit  (mode_hit)
  );

  // scan: sample k arrives in the cycle after its read
  assign k      = cnt_r[3:0] - 4'd1;
  assign col_v  = col_hit ? col_q : '0;
  assign row_v  = row_hit ? row_q : '0;
  assign same_x = (k == 4'd0) || (col_v[VW-1:4] == x0_r[VW-1:4]);
  assign same_y = (k == 4'd0) || (row_v[VW-1:4] == y0_r[VW-1:4]);

  // corners in order top-left, top-right, bottom-left, bottom-right
  assign c_sel  = cnt_r[1:0];
  assign xs     = c_sel[0] ? x15_r : x0_r;
  assign ys     = c_sel[1] ? y15_r : y0_r;
  assign in_layer = !xs[VW-1] && !ys[VW-1] &&
                    (xs[VW-2:0] < (VW-1)'(cfg.width)) &&
                    (ys[VW-2:0] < (VW-1)'(cfg.height));
  assign crn_addr = MW'(ys[12:4]) * MW'(cfg.stride) + MW'(xs[12:4]);
  assign c_done   = cnt_r[1:0] - 2'd2;

  always_ff @(posedge clk) begin
    if (eval_acc) begin
      mb_col_r <= item.mb_col;
      mb_row_r <= item.mb_row;
    end
    if ((state_r == svc_iimbc_pkg::ST_SCAN) && (cnt_r != '0)) begin
      if (k == 4'd0) begin
        x0_r <= col_v;
        y0_r <= row_v;
      end
      if (k == svc_iimbc_pkg::MB_LAST) begin
        x15_r <= col_v;
        y15_r <= row_v;
      end
    end
    addr_r <= crn_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= svc_iimbc_pkg::ST_IDLE;
      cnt_r     <= '0;
      cx_r      <= '0;
      cy_r      <= '0;
      cx_done_r <= 1'b0;
      cy_done_r <= 1'b0;
      intra_r   <= '0;
      ok1_r     <= 1'b0;
      ok2_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ok1_r   <= (state_r == svc_iimbc_pkg::ST_CORNER) &&
                 (cnt_r < svc_iimbc_pkg::CORNER_ISSUE) && in_layer;
      ok2_r   <= ok1_r;
      if (eval_acc) begin
        cx_r      <= '0;
        cy_r      <= '0;
        cx_done_r <= 1'b0;
        cy_done_r <= 1'b0;
        intra_r   <= '0;
      end
      if ((state_r == svc_iimbc_pkg::ST_SCAN) && (cnt_r != '0)) begin
        if (!cx_done_r) begin
          if (same_x) begin
            cx_r <= svc_iimbc_pkg::CROSS_W'(k) + 1'b1;
          end else begin
            cx_done_r <= 1'b1;
          end
        end
        if (!cy_done_r) begin
          if (same_y) begin
            cy_r <= svc_iimbc_pkg::CROSS_W'(k) + 1'b1;
          end else begin
            cy_done_r <= 1'b1;
          end
        end
      end
      if ((state_r == svc_iimbc_pkg::ST_CORNER) && (cnt_r >= svc_iimbc_pkg::CORNER_FIRST)) begin
        intra_r[c_done] <= ok2_r && mode_hit && ($signed(mode_q) > $signed(cfg.limit));
      end
    end
  end

  assign ii = |intra_r;

  always_comb begin
    res.intra_inter        = ii;
    res.top_left_intra     = intra_r[0];
    res.top_right_intra    = intra_r[1];
    res.bottom_left_intra  = intra_r[2];
    res.bottom_right_intra = intra_r[3];
    res.cross_x            = ii ? cx_r : '0;
    res.cross_y            = ii ? cy_r : '0;
  end

  `SVC_IIMBC_ASSERT(a_cross_range, clk, rst_n, (state_r != svc_iimbc_pkg::ST_CORNER) || (cx_r != 5'd0 && cx_r <= 5'd16 && cy_r != 5'd0 && cy_r <= 5'd16), "cross count out of 1..16 after scan")
  `SVC_IIMBC_ASSERT_NEXT(a_scan_to_corner, clk, rst_n, state_r == svc_iimbc_pkg::ST_SCAN && cnt_r == svc_iimbc_pkg::SCAN_LAST, state_r == svc_iimbc_pkg::ST_CORNER, "scan did not hand over to corner lookups")
  `SVC_IIMBC_ASSERT(a_zero_result, clk, rst_n, !res_valid || res.intra_inter || (res.cross_x == 5'd0 && res.cross_y == 5'd0), "non-intra-inter result carries cross counts")
  `SVC_IIMBC_ASSERT(a_write_idle, clk, rst_n, !(col_we || row_we || mode_we) || state_r == svc_iimbc_pkg::ST_IDLE, "table write while an evaluation is in flight")

endmodule

`default_nettype wire

>>> rtl/svc_intra_inter_mb_classifier.sv
// Top level of the intra-inter macroblock classifier.
//
// channel  dir  handshake          payload
// in       in   in_tvalid/tready   in_tdata[44:0], in_tuser[1:0]
// out      out  out_tvalid/tready  out_tdata[14:0]
// cfg      in   cfg_we             cfg_index[1:0], cfg_wdata[12:0]
//
// Table writes can stream back to back while no evaluation is in flight.
// An evaluation with base mode makes 16 reads of the projection RAMs,
// then 4 lookups in the mode RAM over a 2-deep read pipeline, then the result.
// Without base mode an evaluation goes straight to the result.
// rst_n is synchronous, active low; the tables are not cleared.
// A result waits in the output register; a stall holds the block before its next input.
`default_nettype none

module svc_intra_inter_mb_classifier #(
  parameter int unsigned MAX_LAYER_WIDTH  = svc_iimbc_pkg::MAX_LAYER_WIDTH_DEF,
  parameter int unsigned MAX_LAYER_HEIGHT = svc_iimbc_pkg::MAX_LAYER_HEIGHT_DEF,
  parameter int unsigned MODE_TABLE_DEPTH = svc_iimbc_pkg::MODE_TABLE_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // table_index, table_value, mb_col, mb_row, base_mode
  input  wire logic [svc_iimbc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  wire logic [1:0]                            in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // intra_inter, top_left_intra, top_right_intra, bottom_left_intra,
  // bottom_right_intra, cross_x, cross_y
  output logic      [svc_iimbc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                                  cfg_we,
  input  wire logic [svc_iimbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [svc_iimbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  svc_iimbc_pkg::iimbc_cfg_t    cfg_r;
  svc_iimbc_pkg::iimbc_item_t   item;
  svc_iimbc_pkg::iimbc_result_t res;
  logic                                  res_valid;
  logic                                  slot_free;
  logic                                  out_valid_r;
  logic [svc_iimbc_pkg::OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= '0;
      cfg_r.height <= '0;
      cfg_r.stride <= svc_iimbc_pkg::STRIDE_RESET;
      cfg_r.limit  <= '0;
    end else if (cfg_we) begin
      unique case (svc_iimbc_pkg::iimbc_reg_t'(cfg_index))
        svc_iimbc_pkg::REG_WIDTH:  cfg_r.width  <= cfg_wdata;
        svc_iimbc_pkg::REG_HEIGHT: cfg_r.height <= cfg_wdata;
        svc_iimbc_pkg::REG_STRIDE: cfg_r.stride <= cfg_wdata[svc_iimbc_pkg::STRIDE_W-1:0];
        svc_iimbc_pkg::REG_LIMIT:  cfg_r.limit  <= cfg_wdata[svc_iimbc_pkg::MCODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.mode        = svc_iimbc_pkg::iimbc_op_t'(in_tuser);
    item.table_index = in_tdata[13:0];
    item.table_value = in_tdata[29:14];
    item.mb_col      = in_tdata[36:30];
    item.mb_row      = in_tdata[43:37];
    item.base_mode   = in_tdata[44];
  end

  assign slot_free = !out_valid_r || out_tready;

  svc_iimbc_seq #(
    .MAX_LAYER_WIDTH  (MAX_LAYER_WIDTH),
    .MAX_LAYER_HEIGHT (MAX_LAYER_HEIGHT),
    .MODE_TABLE_DEPTH (MODE_TABLE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .cfg       (cfg_r),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= {1'b0, res.cross_y, res.cross_x, res.bottom_right_intra,
                     res.bottom_left_intra, res.top_right_intra, res.top_left_intra,
                     res.intra_inter};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> tb/sv/svc_intra_inter_mb_classifier_checker.sv
`timescale 1ns / 100ps
// Checker for the intra-inter macroblock classifier: predicts each result and compares it.
module svc_intra_inter_mb_classifier_checker
  import svc_iimbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending
);

  logic signed [VALUE_W-1:0] col_proj [MAX_LAYER_WIDTH_DEF];
  logic signed [VALUE_W-1:0] row_proj [MAX_LAYER_HEIGHT_DEF];
  logic signed [MCODE_W-1:0] ref_mode [MODE_TABLE_DEPTH_DEF];
  int lay_w, lay_h, stride, limit;
  int errs;
  iimbc_result_t mb_class_q[$];

  function automatic logic corner_is_intra(int x, int y);
    int addr;
    if (x < 0 || y < 0 || x >= lay_w || y >= lay_h) return 1'b0;
    addr = (y >> 4) * stride + (x >> 4);
    if (addr >= int'(MODE_TABLE_DEPTH_DEF)) return 1'b0;
    return ref_mode[addr] > limit;
  endfunction

  // count of leading entries that stay in the same reference MB (floor of value / 16)
  function automatic int first_cross(bit on_rows, int base);
    int k, start;
    start = (on_rows ? row_proj[base] : col_proj[base]) >>> 4;
    for (k = 0; k < 16; k++)
      if (((on_rows ? row_proj[base + k] : col_proj[base + k]) >>> 4) != start) break;
    return k;
  endfunction

  function automatic iimbc_result_t classify(logic [MBPOS_W-1:0] c, logic [MBPOS_W-1:0] r,
                                             logic base);
    iimbc_result_t res;
    int fx, fy, x0, x15, y0, y15;
    res = '0;
    if (!base) return res;
    fx = 16 * c;
    fy = 16 * r;
    x0 = col_proj[fx];
    x15 = col_proj[fx + 15];
    y0 = row_proj[fy];
    y15 = row_proj[fy + 15];
    res.top_left_intra = corner_is_intra(x0, y0);
    res.top_right_intra = corner_is_intra(x15, y0);
    res.bottom_left_intra = corner_is_intra(x0, y15);
    res.bottom_right_intra = corner_is_intra(x15, y15);
    if (!(res.top_left_intra || res.top_right_intra || res.bottom_left_intra ||
          res.bottom_right_intra)) return '0;
    res.intra_inter = 1'b1;
    res.cross_x = CROSS_W'(first_cross(1'b0, fx));
    res.cross_y = CROSS_W'(first_cross(1'b1, fy));
    return res;
  endfunction

  task automatic check_field(string name, logic [CROSS_W-1:0] want, logic [CROSS_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    iimbc_result_t want;
    logic [OUT_TDATA_W-1:0] d;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    if (!rst_n) begin
      lay_w = 0;
      lay_h = 0;
      stride = int'(STRIDE_RESET);
      limit = 0;
      mb_class_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  lay_w = int'(cfg_wdata);
          REG_HEIGHT: lay_h = int'(cfg_wdata);
          REG_STRIDE: stride = int'(cfg_wdata[STRIDE_W-1:0]);
          REG_LIMIT:  limit = int'(signed'(cfg_wdata[MCODE_W-1:0]));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        // tdata: table_index, table_value, mb_col, mb_row, base_mode
        idx = in_tdata[13:0];
        val = in_tdata[29:14];
        case (iimbc_op_t'(in_tuser))
          OP_COL_WR:  if (idx < MAX_LAYER_WIDTH_DEF) col_proj[idx] = val;
          OP_ROW_WR:  if (idx < MAX_LAYER_HEIGHT_DEF) row_proj[idx] = val;
          OP_MODE_WR: if (idx < MODE_TABLE_DEPTH_DEF) ref_mode[idx] = val[MCODE_W-1:0];
          OP_EVAL:    mb_class_q.push_back(classify(in_tdata[36:30], in_tdata[43:37],
                                                    in_tdata[44]));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        d = out_tdata;
        if (mb_class_q.size() == 0) begin
          $display("%0t: result %h transferred, none expected", $time, d);
          errs++;
        end else begin
          want = mb_class_q.pop_front();
          check_field("intra_inter", want.intra_inter, d[0]);
          check_field("top_left_intra", want.top_left_intra, d[1]);
          check_field("top_right_intra", want.top_right_intra, d[2]);
          check_field("bottom_left_intra", want.bottom_left_intra, d[3]);
          check_field("bottom_right_intra", want.bottom_right_intra, d[4]);
          check_field("cross_x", want.cross_x, d[9:5]);
          check_field("cross_y", want.cross_y, d[14:10]);
        end
      end
    end
    fail_count <= errs;
    pending <= mb_class_q.size();
  end

endmodule

>>> tb/sv/svc_intra_inter_mb_classifier_tb.sv
`timescale 1ns / 100ps
// Testbench top for the intra-inter macroblock classifier: stimulus, idling and verdict.
module svc_intra_inter_mb_classifier_tb;
  import svc_iimbc_pkg::*;

  localparam int ITEM_TARGET  = 1100;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  int fail_count, pending;

  bit calm;
  int sent, idle_cycles;
  int mood_at = 0;
  int hold_at = 150;
  int cur_w, cur_h, cur_s, cur_l;
  // what has been loaded so far, so that no unwritten entry is ever read
  int col_v [MAX_LAYER_WIDTH_DEF];
  bit col_ok [MAX_LAYER_WIDTH_DEF];
  int row_v [MAX_LAYER_HEIGHT_DEF];
  bit row_ok [MAX_LAYER_HEIGHT_DEF];
  bit mode_ok [MODE_TABLE_DEPTH_DEF];
  int pool_c [8];
  int pool_r [8];

  svc_intra_inter_mb_classifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  svc_intra_inter_mb_classifier_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("svc_intra_inter_mb_classifier_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sink
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [VALUE_W-1:0] clip16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return VALUE_W'(v);
  endfunction

  // reference MB address read for a corner, or -1 when the corner reads nothing
  function automatic int corner_addr(int x, int y);
    int a;
    if (x < 0 || y < 0 || x >= cur_w || y >= cur_h) return -1;
    a = (y >> 4) * cur_s + (x >> 4);
    if (a >= int'(MODE_TABLE_DEPTH_DEF)) return -1;
    return a;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_code();
    int code;
    if ($urandom_range(0, 1) == 0) begin
      code = int'($urandom_range(0, 255)) - 128;
    end else begin
      code = cur_l + int'($urandom_range(0, 4)) - 2;
      if (code > 127) code = 127;
      if (code < -128) code = -128;
    end
    return {8'($urandom), 8'(code)};
  endfunction

  task automatic send_item(iimbc_op_t op, int idx, logic [VALUE_W-1:0] val,
                           logic [MBPOS_W-1:0] c, logic [MBPOS_W-1:0] r, logic b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, b, r, c, val, 14'(idx)};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic put_proj(bit on_rows, int idx, logic [VALUE_W-1:0] val);
    send_item(on_rows ? OP_ROW_WR : OP_COL_WR, idx, val, 7'($urandom), 7'($urandom),
              1'($urandom));
    if (on_rows && idx < int'(MAX_LAYER_HEIGHT_DEF)) begin
      row_v[idx] = int'(signed'(val));
      row_ok[idx] = 1'b1;
    end else if (!on_rows && idx < int'(MAX_LAYER_WIDTH_DEF)) begin
      col_v[idx] = int'(signed'(val));
      col_ok[idx] = 1'b1;
    end
  endtask

  task automatic put_mode(int idx, logic [VALUE_W-1:0] val);
    send_item(OP_MODE_WR, idx, val, 7'($urandom), 7'($urandom), 1'($urandom));
    mode_ok[idx] = 1'b1;
  endtask

  // loads the 16 projections of one MB as a ramp (only unwritten ones unless redo), so crossings land at varied offsets
  task automatic fill_proj(bit on_rows, int mb, bit redo);
    int lim, start, step, k, idx, v;
    lim = on_rows ? cur_h : cur_w;
    start = int'($urandom_range(0, lim + 48)) - 32;
    if ($urandom_range(0, 7) == 0) start = int'($urandom_range(0, 65535)) - 32768;
    step = $urandom_range(0, 3);
    for (k = 0; k < 16; k++) begin
      idx = mb * 16 + k;
      v = start + k * step;
      if ($urandom_range(0, 19) == 0) v = int'($urandom_range(0, 65535)) - 32768;
      if (redo || !(on_rows ? row_ok[idx] : col_ok[idx])) put_proj(on_rows, idx, clip16(v));
    end
  endtask

  task automatic eval_mb(int c, int r, bit base, bit remode);
    int i, j, a;
    int xs [2];
    int ys [2];
    if (base) begin
      fill_proj(1'b0, c, 1'b0);
      fill_proj(1'b1, r, 1'b0);
      xs[0] = col_v[c * 16];
      xs[1] = col_v[c * 16 + 15];
      ys[0] = row_v[r * 16];
      ys[1] = row_v[r * 16 + 15];
      for (i = 0; i < 2; i++)
        for (j = 0; j < 2; j++) begin
          a = corner_addr(xs[i], ys[j]);
          if (a >= 0 && (remode || !mode_ok[a])) put_mode(a, pick_code());
        end
    end
    send_item(OP_EVAL, int'($urandom_range(0, 16383)), 16'($urandom), 7'(c), 7'(r), base);
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_layer(int w, int h, int s, int l);
    wait_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= REG_STRIDE;
    cfg_wdata <= {5'($urandom), 8'(s)};
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_wdata <= {5'($urandom), 8'(l)};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
    cur_s = s;
    cur_l = l;
  endtask

  task automatic directed_checks();
    int k;
    set_layer(2048, 2048, 128, 0);
    put_proj(1'b0, 2048, 16'h1234);
    put_proj(1'b1, 16383, 16'h8000);
    put_proj(1'b0, 16383, 16'h7fff);
    put_mode(0, 16'h017f);
    put_mode(16383, 16'hff80);
    for (k = 0; k < 16; k++) begin
      put_proj(1'b0, k, 16'(k));
      put_proj(1'b1, k, 16'(k));
    end
    eval_mb(0, 0, 1'b1, 1'b0);
    eval_mb(0, 0, 1'b0, 1'b0);
    put_proj(1'b0, 8, 16'd16);
    eval_mb(0, 0, 1'b1, 1'b0);
    put_proj(1'b0, 0, 16'hffff);
    eval_mb(0, 0, 1'b1, 1'b0);
    put_proj(1'b1, 15, 16'd2047);
    eval_mb(0, 0, 1'b1, 1'b0);
    put_proj(1'b1, 15, 16'd2048);
    eval_mb(0, 0, 1'b1, 1'b0);
    put_mode(0, 16'h5500);
    eval_mb(0, 0, 1'b1, 1'b0);
    eval_mb(127, 127, 1'b1, 1'b0);
  endtask

  task automatic random_sequence();
    int pick, s, c, r, idx, v;
    bit on_rows;
    if (sent >= mood_at) begin
      calm = ($urandom_range(0, 4) == 0);
      mood_at = sent + 60;
    end
    if (sent >= hold_at) begin
      wait_results();
      hold_at = sent + 150;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      s = $urandom_range(0, 7);
      if ($urandom_range(0, 6) == 0) begin
        pool_c[s] = $urandom_range(0, 127);
        pool_r[s] = $urandom_range(0, 127);
      end
      c = pool_c[s];
      r = pool_r[s];
      case ($urandom_range(0, 9))
        0: fill_proj(1'b0, c, 1'b1);
        1: fill_proj(1'b1, r, 1'b1);
        2, 3: begin
          on_rows = 1'($urandom);
          idx = (on_rows ? r : c) * 16 + int'($urandom_range(0, 15));
          v = (on_rows ? row_v[idx] : col_v[idx]) + int'($urandom_range(0, 32)) - 16;
          put_proj(on_rows, idx, clip16(v));
        end
        default: ;
      endcase
      eval_mb(c, r, $urandom_range(0, 15) != 0, $urandom_range(0, 2) == 0);
    end else if (pick < 72) begin
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 2047);
      put_proj(1'($urandom), idx, 16'($urandom));
    end else if (pick < 88) begin
      put_mode($urandom_range(0, 16383), 16'($urandom));
    end else begin
      eval_mb($urandom_range(0, 127), $urandom_range(0, 127), 1'b0, 1'b0);
    end
  endtask

  initial begin : stimulus
    int ph;
    for (ph = 0; ph < 8; ph++) begin
      pool_c[ph] = $urandom_range(0, 127);
      pool_r[ph] = $urandom_range(0, 127);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_layer(4096, 4096, 128, 0);
        1: set_layer(0, 0, 64, -128);
        2: set_layer(1024, 512, 1, -128);
        3: set_layer(4096, 4096, 128, 127);
        default: set_layer($urandom_range(16, 4096), $urandom_range(16, 4096),
                           $urandom_range(1, 128), int'($urandom_range(0, 255)) - 128);
      endcase
      while (sent < ITEM_TARGET * (ph + 1) / 6) random_sequence();
    end
    wait_results();
    if (fail_count == 0 && pending == 0) begin
      $display("svc_intra_inter_mb_classifier_tb: done, clean");
    end else begin
      $display("svc_intra_inter_mb_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule
